// ----- rtl/gtao_pkg.sv -----
package gtao_pkg;

    localparam int POS_W         = 24;
    localparam int ROT_W         = 18;
    localparam int ROT_FRAC      = 16;
    localparam int TAN_W         = 32;
    localparam int FLAG_W        = 2;
    localparam int IDX_W         = 3;
    localparam int FRAC_BITS_DEF = 16;

    // rotation datapath
    localparam int PROD_W = 2 * ROT_W;          // quaternion pair product
    localparam int RM_W   = PROD_W + 2;         // matrix entry, 32 fraction bits
    localparam int MV_W   = RM_W + POS_W;       // matrix times vector term
    localparam int ACC_W  = 64;                 // row sum plus rounding bias
    localparam int SAT_W  = ACC_W - 2 * ROT_FRAC + 2;

    // tangent datapath
    localparam int U_W  = POS_W + 1;            // target minus eye
    localparam int N2_W = 50;                   // |u|^2
    localparam int P_W  = 51;                   // u . look
    localparam int AP_W = 49;                   // |p|
    localparam int QB   = 34;                   // quotient bits kept

    localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(1 << ROT_FRAC);
    localparam logic [TAN_W-1:0] TAN_MAX = {1'b0, {(TAN_W-1){1'b1}}};
    localparam logic [TAN_W-1:0] TAN_MIN = {1'b1, {(TAN_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } t_reg_idx;

    typedef enum logic [FLAG_W-1:0] {
        FLAG_OK    = 2'd0,
        FLAG_SAT   = 2'd1,
        FLAG_UNDEF = 2'd2
    } t_flag;

    typedef logic [2:0][POS_W-1:0] t_vec;

    typedef struct packed {
        logic signed [ROT_W-1:0] w;
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } t_quat;

    // travels alongside the radicand / root / quotient
    typedef struct packed {
        t_vec            we;
        t_vec            wl;
        logic            zero;
        logic            neg;
        logic [AP_W-1:0] ap;
    } t_tag;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'((1 << (POS_W - 1)) - 1);
        lo = -hi - SAT_W'(1);
        if (v > hi) begin
            return POS_W'(hi);
        end else if (v < lo) begin
            return POS_W'(lo);
        end
        return POS_W'(v);
    endfunction

endpackage

// ----- rtl/gaze_target_angular_offset.sv -----
// Throughput: one request per cycle while o_stall is low; the bit-per-stage square root
// and divider are fully pipelined, so the row of stages sets latency, not rate.
// Reset (i_rst_n, synchronous, active low) empties the pipeline and the output
// register and loads the identity rotation and zero translation.
module gaze_target_angular_offset import gtao_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [POS_W-1:0]         i_cfg_data,
    // request channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [POS_W-1:0]  i_eye_x,
    input  logic signed [POS_W-1:0]  i_eye_y,
    input  logic signed [POS_W-1:0]  i_eye_z,
    input  logic signed [POS_W-1:0]  i_look_x,
    input  logic signed [POS_W-1:0]  i_look_y,
    input  logic signed [POS_W-1:0]  i_look_z,
    input  logic signed [POS_W-1:0]  i_target_x,
    input  logic signed [POS_W-1:0]  i_target_y,
    input  logic signed [POS_W-1:0]  i_target_z,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [POS_W-1:0]  o_world_eye_x,
    output logic signed [POS_W-1:0]  o_world_eye_y,
    output logic signed [POS_W-1:0]  o_world_eye_z,
    output logic signed [POS_W-1:0]  o_world_look_x,
    output logic signed [POS_W-1:0]  o_world_look_y,
    output logic signed [POS_W-1:0]  o_world_look_z,
    output logic signed [TAN_W-1:0]  o_offset_tan,
    output logic [FLAG_W-1:0]        o_offset_flag
);

    // Pipeline map:
    //   gtao_rot   4 stages  quaternion products, matrix, 18 multiplies, round/shift/saturate
    //   gtao_geom  7 stages  u = target - eye, |u|^2 and u.look, |p|, p^2, radicand
    //   gtao_sqrt  25+F      one root bit per stage
    //   gtao_div   36        overflow check, 34 quotient bits, rounding/saturation
    //   output register 1
    // All stages move together on pipe_en. They hold only when the last divider
    // stage has a result and the output register is full and stalled, so bubbles
    // still fill while a result waits downstream.

    localparam int RW = N2_W + 2 * FRAC_BITS;
    localparam int SW = RW / 2;

    t_quat r_quat;
    t_vec  r_shift;

    logic  pipe_en;
    t_vec  eye, look, tgt;

    logic  rot_v;
    t_vec  rot_we, rot_wl, rot_tgt;

    logic          geo_v;
    logic [RW-1:0] geo_rad;
    t_tag          geo_tag;

    logic          sq_v;
    logic [SW-1:0] sq_root;
    t_tag          sq_tag;

    logic              dv_v;
    logic [TAN_W-1:0]  dv_tan;
    logic [FLAG_W-1:0] dv_flag;
    t_tag              dv_tag;

    logic              r_ovalid;
    t_vec              r_owe, r_owl;
    logic [TAN_W-1:0]  r_otan;
    logic [FLAG_W-1:0] r_oflag;
    logic              out_load;

    // always ready, unchecked: user must only change registers while the pipe is empty
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= ROT_ONE;
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
            r_shift  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ROT_W:   r_quat.w   <= i_cfg_data[ROT_W-1:0];
                REG_ROT_X:   r_quat.x   <= i_cfg_data[ROT_W-1:0];
                REG_ROT_Y:   r_quat.y   <= i_cfg_data[ROT_W-1:0];
                REG_ROT_Z:   r_quat.z   <= i_cfg_data[ROT_W-1:0];
                REG_SHIFT_X: r_shift[0] <= i_cfg_data;
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    assign eye  = {i_eye_z, i_eye_y, i_eye_x};
    assign look = {i_look_z, i_look_y, i_look_x};
    assign tgt  = {i_target_z, i_target_y, i_target_x};

    // output register takes a result when empty or being drained
    assign out_load = !r_ovalid || !i_stall;
    assign pipe_en  = !dv_v || out_load;
    assign o_stall  = !pipe_en;

    gtao_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_valid),
        .i_quat  (r_quat),
        .i_shift (r_shift),
        .i_eye   (eye),
        .i_look  (look),
        .i_tgt   (tgt),
        .o_valid (rot_v),
        .o_we    (rot_we),
        .o_wl    (rot_wl),
        .o_tgt   (rot_tgt)
    );

    gtao_geom #(
        .FRAC_BITS (FRAC_BITS)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (rot_v),
        .i_we    (rot_we),
        .i_wl    (rot_wl),
        .i_tgt   (rot_tgt),
        .o_valid (geo_v),
        .o_rad   (geo_rad),
        .o_tag   (geo_tag)
    );

    gtao_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (geo_v),
        .i_rad   (geo_rad),
        .i_tag   (geo_tag),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    gtao_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (sq_v),
        .i_root  (sq_root),
        .i_tag   (sq_tag),
        .o_valid (dv_v),
        .o_tan   (dv_tan),
        .o_flag  (dv_flag),
        .o_tag   (dv_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_owe   <= dv_tag.we;
            r_owl   <= dv_tag.wl;
            r_otan  <= dv_tan;
            r_oflag <= dv_flag;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_world_eye_x  = r_owe[0];
    assign o_world_eye_y  = r_owe[1];
    assign o_world_eye_z  = r_owe[2];
    assign o_world_look_x = r_owl[0];
    assign o_world_look_y = r_owl[1];
    assign o_world_look_z = r_owl[2];
    assign o_offset_tan   = r_otan;
    assign o_offset_flag  = r_oflag;

endmodule

// ----- rtl/gtao_rot.sv -----
module gtao_rot import gtao_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_quat i_quat,
    input  t_vec  i_shift,
    input  t_vec  i_eye,
    input  t_vec  i_look,
    input  t_vec  i_tgt,
    output logic  o_valid,
    output t_vec  o_we,
    output t_vec  o_wl,
    output t_vec  o_tgt
);

    localparam logic signed [RM_W-1:0]  ONE  = RM_W'(64'd1 << (2 * ROT_FRAC));
    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(64'd1 << (2 * ROT_FRAC - 1));

    // stage 1: quaternion pair products
    logic                     r1_v;
    logic signed [PROD_W-1:0] r1_xx, r1_yy, r1_zz, r1_xy, r1_xz, r1_yz, r1_wx, r1_wy, r1_wz;
    t_vec                     r1_eye, r1_look, r1_tgt;
    // stage 2: rotation matrix
    logic                     r2_v;
    logic signed [RM_W-1:0]   r2_rm [3][3];
    logic signed [RM_W-1:0]   n2_rm [3][3];
    t_vec                     r2_eye, r2_look, r2_tgt;
    // stage 3: matrix times vector terms
    logic                     r3_v;
    logic signed [MV_W-1:0]   r3_pe [3][3];
    logic signed [MV_W-1:0]   r3_pl [3][3];
    t_vec                     r3_tgt;
    // stage 4: row sums, rounding, translation, saturation
    logic                     r4_v;
    t_vec                     r4_we, r4_wl, r4_tgt;
    t_vec                     n4_we, n4_wl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_comb begin
        logic signed [RM_W-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
        e_xx = RM_W'(r1_xx) <<< 1;
        e_yy = RM_W'(r1_yy) <<< 1;
        e_zz = RM_W'(r1_zz) <<< 1;
        e_xy = RM_W'(r1_xy) <<< 1;
        e_xz = RM_W'(r1_xz) <<< 1;
        e_yz = RM_W'(r1_yz) <<< 1;
        e_wx = RM_W'(r1_wx) <<< 1;
        e_wy = RM_W'(r1_wy) <<< 1;
        e_wz = RM_W'(r1_wz) <<< 1;
        n2_rm[0][0] = ONE - (e_yy + e_zz);
        n2_rm[0][1] = e_xy - e_wz;
        n2_rm[0][2] = e_xz + e_wy;
        n2_rm[1][0] = e_xy + e_wz;
        n2_rm[1][1] = ONE - (e_xx + e_zz);
        n2_rm[1][2] = e_yz - e_wx;
        n2_rm[2][0] = e_xz - e_wy;
        n2_rm[2][1] = e_yz + e_wx;
        n2_rm[2][2] = ONE - (e_xx + e_yy);
    end

    always_comb begin
        logic signed [ACC_W-1:0]            se, sl;
        logic signed [ACC_W-2*ROT_FRAC-1:0] re, rl;
        logic signed [SAT_W-1:0]            te, tl;
        for (int i = 0; i < 3; i++) begin
            se = ACC_W'(r3_pe[i][0]) + ACC_W'(r3_pe[i][1]) + ACC_W'(r3_pe[i][2]) + BIAS;
            sl = ACC_W'(r3_pl[i][0]) + ACC_W'(r3_pl[i][1]) + ACC_W'(r3_pl[i][2]) + BIAS;
            re = $signed(se[ACC_W-1:2*ROT_FRAC]);
            rl = $signed(sl[ACC_W-1:2*ROT_FRAC]);
            te = SAT_W'(re) + SAT_W'($signed(i_shift[i]));
            tl = SAT_W'(rl);
            n4_we[i] = sat_pos(te);
            n4_wl[i] = sat_pos(tl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_xx   <= i_quat.x * i_quat.x;
            r1_yy   <= i_quat.y * i_quat.y;
            r1_zz   <= i_quat.z * i_quat.z;
            r1_xy   <= i_quat.x * i_quat.y;
            r1_xz   <= i_quat.x * i_quat.z;
            r1_yz   <= i_quat.y * i_quat.z;
            r1_wx   <= i_quat.w * i_quat.x;
            r1_wy   <= i_quat.w * i_quat.y;
            r1_wz   <= i_quat.w * i_quat.z;
            r1_eye  <= i_eye;
            r1_look <= i_look;
            r1_tgt  <= i_tgt;

            r2_rm   <= n2_rm;
            r2_eye  <= r1_eye;
            r2_look <= r1_look;
            r2_tgt  <= r1_tgt;

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_pe[i][j] <= r2_rm[i][j] * $signed(r2_eye[j]);
                    r3_pl[i][j] <= r2_rm[i][j] * $signed(r2_look[j]);
                end
            end
            r3_tgt <= r2_tgt;

            r4_we  <= n4_we;
            r4_wl  <= n4_wl;
            r4_tgt <= r3_tgt;
        end
    end

    assign o_valid = r4_v;
    assign o_we    = r4_we;
    assign o_wl    = r4_wl;
    assign o_tgt   = r4_tgt;

endmodule

// ----- rtl/gtao_geom.sv -----
module gtao_geom import gtao_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  t_vec                          i_we,
    input  t_vec                          i_wl,
    input  t_vec                          i_tgt,
    output logic                          o_valid,
    output logic [N2_W+2*FRAC_BITS-1:0]   o_rad,
    output t_tag                          o_tag
);

    localparam int RW   = N2_W + 2 * FRAC_BITS;
    localparam int BW   = 2 * AP_W;
    localparam int CW   = (RW > BW) ? RW : BW;
    localparam int AL_W = (AP_W + 1) / 2;
    localparam int AH_W = AP_W - AL_W;

    logic                        r_v [7];

    logic signed [U_W-1:0]       r1_u [3];
    t_vec                        r1_we, r1_wl;

    logic signed [2*U_W-1:0]     r2_uu [3];
    logic signed [U_W+POS_W-1:0] r2_ul [3];
    t_vec                        r2_we, r2_wl;

    logic [N2_W-1:0]             r3_n2;
    logic signed [P_W-1:0]       r3_p;
    t_vec                        r3_we, r3_wl;

    logic [N2_W-1:0]             r4_n2;
    logic [AP_W-1:0]             r4_ap;
    logic                        r4_zero, r4_neg;
    t_vec                        r4_we, r4_wl;

    logic [N2_W-1:0]             r5_n2;
    logic [2*AH_W-1:0]           r5_hh;
    logic [AH_W+AL_W-1:0]        r5_hl;
    logic [2*AL_W-1:0]           r5_ll;
    logic [AP_W-1:0]             r5_ap;
    logic                        r5_zero, r5_neg;
    t_vec                        r5_we, r5_wl;

    logic [N2_W-1:0]             r6_n2;
    logic [BW-1:0]               r6_b;
    logic [AP_W-1:0]             r6_ap;
    logic                        r6_zero, r6_neg;
    t_vec                        r6_we, r6_wl;

    logic [RW-1:0]               r7_rad;
    t_tag                        r7_tag;

    logic [CW-1:0]               a_ext, b_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 7; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 7; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // radicand |u|^2 * 2^2F - p^2, clamped at zero
    assign a_ext = CW'(r6_n2) << (2 * FRAC_BITS);
    assign b_ext = CW'(r6_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_u[i]  <= U_W'($signed(i_tgt[i])) - U_W'($signed(i_we[i]));
                r2_uu[i] <= r1_u[i] * r1_u[i];
                r2_ul[i] <= r1_u[i] * $signed(r1_wl[i]);
            end
            r1_we <= i_we;
            r1_wl <= i_wl;
            r2_we <= r1_we;
            r2_wl <= r1_wl;

            r3_n2 <= N2_W'(r2_uu[0]) + N2_W'(r2_uu[1]) + N2_W'(r2_uu[2]);
            r3_p  <= P_W'(r2_ul[0]) + P_W'(r2_ul[1]) + P_W'(r2_ul[2]);
            r3_we <= r2_we;
            r3_wl <= r2_wl;

            r4_n2   <= r3_n2;
            r4_ap   <= r3_p[P_W-1] ? AP_W'(-r3_p) : AP_W'(r3_p);
            r4_zero <= (r3_p == '0);
            r4_neg  <= r3_p[P_W-1];
            r4_we   <= r3_we;
            r4_wl   <= r3_wl;

            // p^2 in three partial products
            r5_hh   <= r4_ap[AP_W-1:AL_W] * r4_ap[AP_W-1:AL_W];
            r5_hl   <= r4_ap[AP_W-1:AL_W] * r4_ap[AL_W-1:0];
            r5_ll   <= r4_ap[AL_W-1:0] * r4_ap[AL_W-1:0];
            r5_n2   <= r4_n2;
            r5_ap   <= r4_ap;
            r5_zero <= r4_zero;
            r5_neg  <= r4_neg;
            r5_we   <= r4_we;
            r5_wl   <= r4_wl;

            r6_b    <= (BW'(r5_hh) << (2 * AL_W)) + (BW'(r5_hl) << (AL_W + 1)) + BW'(r5_ll);
            r6_n2   <= r5_n2;
            r6_ap   <= r5_ap;
            r6_zero <= r5_zero;
            r6_neg  <= r5_neg;
            r6_we   <= r5_we;
            r6_wl   <= r5_wl;

            r7_rad      <= (b_ext <= a_ext) ? RW'(a_ext - b_ext) : '0;
            r7_tag.we   <= r6_we;
            r7_tag.wl   <= r6_wl;
            r7_tag.zero <= r6_zero;
            r7_tag.neg  <= r6_neg;
            r7_tag.ap   <= r6_ap;
        end
    end

    assign o_valid = r_v[6];
    assign o_rad   = r7_rad;
    assign o_tag   = r7_tag;

endmodule

// ----- rtl/gtao_sqrt.sv -----
module gtao_sqrt import gtao_pkg::*; #(
    parameter int RW = N2_W + 2 * FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RW-1:0]     i_rad,
    input  t_tag              i_tag,
    output logic              o_valid,
    output logic [RW/2-1:0]   o_root,
    output t_tag              o_tag
);

    localparam int SW = RW / 2;

    // one root bit per stage, most significant first
    logic          r_v   [SW];
    logic [RW-1:0] r_x   [SW];
    logic [RW-1:0] r_res [SW];
    t_tag          r_tag [SW];
    logic [RW-1:0] n_x   [SW];
    logic [RW-1:0] n_res [SW];

    always_comb begin
        logic [RW-1:0] x_in, res_in, one;
        logic [RW:0]   trial;
        for (int k = 0; k < SW; k++) begin
            if (k == 0) begin
                x_in   = i_rad;
                res_in = '0;
            end else begin
                x_in   = r_x[k-1];
                res_in = r_res[k-1];
            end
            one   = RW'(1) << (2 * (SW - 1 - k));
            trial = {1'b0, res_in} + {1'b0, one};
            if ({1'b0, x_in} >= trial) begin
                n_x[k]   = x_in - trial[RW-1:0];
                n_res[k] = (res_in >> 1) + one;
            end else begin
                n_x[k]   = x_in;
                n_res[k] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < SW; k++) begin
                if (k == 0) begin
                    r_v[k] <= i_valid;
                end else begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SW; k++) begin
                r_x[k]   <= n_x[k];
                r_res[k] <= n_res[k];
                if (k == 0) begin
                    r_tag[k] <= i_tag;
                end else begin
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_res[SW-1][SW-1:0];
    assign o_tag   = r_tag[SW-1];

endmodule

// ----- rtl/gtao_div.sv -----
module gtao_div import gtao_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [(N2_W+2*FRAC_BITS)/2-1:0]  i_root,
    input  t_tag                             i_tag,
    output logic                             o_valid,
    output logic [TAN_W-1:0]                 o_tan,
    output logic [FLAG_W-1:0]                o_flag,
    output t_tag                             o_tag
);

    localparam int SW  = (N2_W + 2 * FRAC_BITS) / 2;
    localparam int DW  = SW + FRAC_BITS;        // dividend root * 2^F
    localparam int HW  = DW - QB;
    localparam int CW  = (HW > AP_W) ? HW : AP_W;
    localparam int RMW = AP_W + 1;
    localparam logic [QB:0] LIM_N = (QB + 1)'(64'd1 << (TAN_W - 1));
    localparam logic [QB:0] LIM_P = LIM_N - (QB + 1)'(1);

    logic [DW-1:0]  num;
    logic [HW-1:0]  num_hi;

    // entry stage: quotient overflow check and first partial remainder
    logic           r0_v, r0_ovf;
    logic [RMW-1:0] r0_rem;
    logic [QB-1:0]  r0_nlo;
    t_tag           r0_tag;

    // one quotient bit per stage
    logic           r_v   [QB];
    logic [RMW-1:0] r_rem [QB];
    logic [QB-1:0]  r_q   [QB];
    logic [QB-1:0]  r_nlo [QB];
    logic           r_ovf [QB];
    t_tag           r_tag [QB];
    logic [RMW-1:0] n_rem [QB];
    logic [QB-1:0]  n_q   [QB];

    // rounding and saturation
    logic              rf_v;
    logic [TAN_W-1:0]  rf_tan;
    logic [FLAG_W-1:0] rf_flag;
    t_tag              rf_tag;
    logic [TAN_W-1:0]  n_tan;
    t_flag             n_flag;

    assign num    = DW'(i_root) << FRAC_BITS;
    assign num_hi = num[DW-1:QB];

    always_comb begin
        logic [RMW-1:0] rem_in, t;
        logic [QB-1:0]  q_in, nlo_in;
        for (int k = 0; k < QB; k++) begin
            if (k == 0) begin
                rem_in = r0_rem;
                q_in   = '0;
                nlo_in = r0_nlo;
            end else begin
                rem_in = r_rem[k-1];
                q_in   = r_q[k-1];
                nlo_in = r_nlo[k-1];
            end
            t = {rem_in[RMW-2:0], nlo_in[QB-1-k]};
            if (t >= RMW'(r0_tag.ap) && k == 0 || k != 0 && t >= RMW'(r_tag[k-1].ap)) begin
                n_rem[k] = t - (k == 0 ? RMW'(r0_tag.ap) : RMW'(r_tag[k-1].ap));
                n_q[k]   = {q_in[QB-2:0], 1'b1};
            end else begin
                n_rem[k] = t;
                n_q[k]   = {q_in[QB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic        rnd;
        logic [QB:0] qr;
        rnd = {r_rem[QB-1], 1'b0} >= (RMW + 1)'(r_tag[QB-1].ap);
        qr  = (QB + 1)'(r_q[QB-1]) + (QB + 1)'(rnd);
        if (r_tag[QB-1].zero) begin
            n_tan  = '0;
            n_flag = FLAG_UNDEF;
        end else if (!r_tag[QB-1].neg) begin
            if (r_ovf[QB-1] || qr > LIM_P) begin
                n_tan  = TAN_MAX;
                n_flag = FLAG_SAT;
            end else begin
                n_tan  = TAN_W'(qr);
                n_flag = FLAG_OK;
            end
        end else begin
            if (r_ovf[QB-1] || qr > LIM_N) begin
                n_tan  = TAN_MIN;
                n_flag = FLAG_SAT;
            end else begin
                n_tan  = TAN_W'((QB + 1)'(0) - qr);
                n_flag = FLAG_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            rf_v <= 1'b0;
            for (int k = 0; k < QB; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r0_v <= i_valid;
            for (int k = 0; k < QB; k++) begin
                if (k == 0) begin
                    r_v[k] <= r0_v;
                end else begin
                    r_v[k] <= r_v[k-1];
                end
            end
            rf_v <= r_v[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_ovf <= CW'(num_hi) >= CW'(i_tag.ap);
            r0_rem <= RMW'(num_hi);
            r0_nlo <= num[QB-1:0];
            r0_tag <= i_tag;
            for (int k = 0; k < QB; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                if (k == 0) begin
                    r_nlo[k] <= r0_nlo;
                    r_ovf[k] <= r0_ovf;
                    r_tag[k] <= r0_tag;
                end else begin
                    r_nlo[k] <= r_nlo[k-1];
                    r_ovf[k] <= r_ovf[k-1];
                    r_tag[k] <= r_tag[k-1];
                end
            end
            rf_tan  <= n_tan;
            rf_flag <= n_flag;
            rf_tag  <= r_tag[QB-1];
        end
    end

    assign o_valid = rf_v;
    assign o_tan   = rf_tan;
    assign o_flag  = rf_flag;
    assign o_tag   = rf_tag;

endmodule

// ----- tb/tb_gaze_target_angular_offset.sv -----
module tb_gaze_target_angular_offset;
    import gtao_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = 16;
    localparam int Q_ONE       = 1 << FRAC;       // 1.0 in Q8.16
    localparam int PIPE_DRAIN  = 120;             // drain wait: block latency plus margin
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 155;
    localparam int HOLD_CYCLES = 400;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;   // no register here, write is dropped

    // one request: eye, look (headset frame) and target (world frame)
    typedef struct {
        int eye[3];
        int look[3];
        int tgt[3];
    } t_gaze_req;

    // one result as the block should deliver it
    typedef struct {
        int    we[3];
        int    wl[3];
        int    tan;
        t_flag flag;
    } t_gaze_res;

    typedef struct {
        t_gaze_req req;
        bit        typed;
        t_gaze_res res;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [POS_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic signed [POS_W-1:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic signed [POS_W-1:0] i_look_x = '0, i_look_y = '0, i_look_z = '0;
    logic signed [POS_W-1:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic signed [POS_W-1:0] o_world_eye_x, o_world_eye_y, o_world_eye_z;
    logic signed [POS_W-1:0] o_world_look_x, o_world_look_y, o_world_look_z;
    logic signed [TAN_W-1:0] o_offset_tan;
    logic [FLAG_W-1:0]       o_offset_flag;

    gaze_target_angular_offset #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_eye_x        (i_eye_x),
        .i_eye_y        (i_eye_y),
        .i_eye_z        (i_eye_z),
        .i_look_x       (i_look_x),
        .i_look_y       (i_look_y),
        .i_look_z       (i_look_z),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_target_z     (i_target_z),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_world_eye_x  (o_world_eye_x),
        .o_world_eye_y  (o_world_eye_y),
        .o_world_eye_z  (o_world_eye_z),
        .o_world_look_x (o_world_look_x),
        .o_world_look_y (o_world_look_y),
        .o_world_look_z (o_world_look_z),
        .o_offset_tan   (o_offset_tan),
        .o_offset_flag  (o_offset_flag)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the frame registers and the offset predictor
    // ---------------------------------------------------------------
    longint    frame_reg[7];
    t_gaze_res pending_offsets[$];

    int  n_cycles     = 0;
    int  n_requests   = 0;
    int  n_results    = 0;
    int  n_mismatch   = 0;
    int  n_sat_seen   = 0;
    int  n_undef_seen = 0;
    int  n_cfg_writes = 0;
    int  sender_gap_pct = 30;
    int  recv_stall_pct = 20;
    bit  hold_req = 1'b0;

    function automatic longint sext_to(longint v, int w);
        longint m;
        m = (64'sd1 <<< w) - 1;
        v = v & m;
        if (v >= (64'sd1 <<< (w - 1))) begin
            v = v - (64'sd1 <<< w);
        end
        return v;
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 64'sd8388607) begin
            return 64'sd8388607;
        end
        if (v < -64'sd8388608) begin
            return -64'sd8388608;
        end
        return v;
    endfunction

    // floor(sqrt(v)) with a root below 2^50
    function automatic longint unsigned root_floor(logic [127:0] v);
        longint unsigned lo, hi, mid;
        logic [127:0] sq;
        lo = 0;
        hi = 64'd1 << 50;
        while (hi - lo > 1) begin
            mid = lo + ((hi - lo) >> 1);
            sq  = 128'(mid) * 128'(mid);
            if (sq <= v) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic t_gaze_res predict_offset(t_gaze_req rq);
        t_gaze_res        res;
        longint           w, x, y, z, one, bias, se, sl, p, tanv;
        longint           rm[3][3];
        longint           u[3];
        longint unsigned  n2, ap, s, q, r;
        logic [127:0]     a, b;
        bit               sat;
        w = frame_reg[REG_ROT_W];
        x = frame_reg[REG_ROT_X];
        y = frame_reg[REG_ROT_Y];
        z = frame_reg[REG_ROT_Z];
        one  = 64'sd1 <<< 32;
        bias = 64'sd1 <<< 31;
        // rotation matrix, 32 fraction bits, no renormalization
        rm[0][0] = one - (2*y*y + 2*z*z); rm[0][1] = 2*x*y - 2*w*z; rm[0][2] = 2*x*z + 2*w*y;
        rm[1][0] = 2*x*y + 2*w*z; rm[1][1] = one - (2*x*x + 2*z*z); rm[1][2] = 2*y*z - 2*w*x;
        rm[2][0] = 2*x*z - 2*w*y; rm[2][1] = 2*y*z + 2*w*x; rm[2][2] = one - (2*x*x + 2*y*y);
        n2 = 0;
        p  = 0;
        for (int i = 0; i < 3; i++) begin
            se = 0;
            sl = 0;
            for (int j = 0; j < 3; j++) begin
                se += rm[i][j] * longint'(rq.eye[j]);
                sl += rm[i][j] * longint'(rq.look[j]);
            end
            res.we[i] = int'(clamp24(((se + bias) >>> 32) + frame_reg[REG_SHIFT_X + i]));
            res.wl[i] = int'(clamp24((sl + bias) >>> 32));
        end
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'(rq.tgt[i]) - longint'(res.we[i]);
            n2 += longint'(u[i] * u[i]);
            p  += u[i] * longint'(res.wl[i]);
        end
        res.tan  = 0;
        res.flag = FLAG_OK;
        if (p == 0) begin
            res.flag = FLAG_UNDEF;
            return res;
        end
        ap = (p < 0) ? -p : p;
        a  = 128'(n2) << (2 * FRAC);
        b  = 128'(ap) * 128'(ap);
        // look longer than unit can drive the radicand negative: clamp to zero
        s  = (b <= a) ? root_floor(a - b) : 0;
        q  = s / ap;
        r  = s % ap;
        sat = (q >= (64'd1 << 33));
        for (int i = 0; i < FRAC && !sat; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ap) begin
                r -= ap;
                q |= 1;
            end
            if (q >= (64'd1 << 33)) begin
                sat = 1'b1;
            end
        end
        if (!sat && (r << 1) >= ap) begin
            q++;
        end
        if (p > 0) begin
            if (sat || q > 64'h7FFF_FFFF) begin
                sat  = 1'b1;
                tanv = 64'sh7FFF_FFFF;
            end else begin
                tanv = q;
            end
        end else begin
            if (sat || q > 64'h8000_0000) begin
                sat  = 1'b1;
                tanv = -64'sh8000_0000;
            end else begin
                tanv = -longint'(q);
            end
        end
        res.tan  = int'(tanv);
        res.flag = sat ? FLAG_SAT : FLAG_OK;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset, watchdog
    // ---------------------------------------------------------------
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     n_cycles, pending_offsets.size());
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Result side: stall pattern and checker
    // ---------------------------------------------------------------
    // Receiver backpressure. A hold request from the sender side parks the
    // output so the pipe fills and pushes back on the input.
    initial begin
        int len;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 199) == 0) begin
                // occasional long stall
                len = $urandom_range(15, 60);
                i_stall <= 1'b1;
                repeat (len - 1) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    function automatic bit field_ok(string name, longint exp_v, longint got_v);
        if (exp_v == got_v) begin
            return 1'b1;
        end
        if (n_mismatch < 10) begin
            $display("result %0d: %s expected %0d got %0d", n_results, name, exp_v, got_v);
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_gaze_res exp_r;
        bit ok;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_offsets.size() == 0) begin
                if (n_mismatch < 10) begin
                    $display("unexpected result at cycle %0d", n_cycles);
                end
                n_mismatch++;
            end else begin
                exp_r = pending_offsets.pop_front();
                ok = 1'b1;
                ok &= field_ok("world_eye_x",  exp_r.we[0], o_world_eye_x);
                ok &= field_ok("world_eye_y",  exp_r.we[1], o_world_eye_y);
                ok &= field_ok("world_eye_z",  exp_r.we[2], o_world_eye_z);
                ok &= field_ok("world_look_x", exp_r.wl[0], o_world_look_x);
                ok &= field_ok("world_look_y", exp_r.wl[1], o_world_look_y);
                ok &= field_ok("world_look_z", exp_r.wl[2], o_world_look_z);
                ok &= field_ok("offset_tan",   exp_r.tan,   o_offset_tan);
                ok &= field_ok("offset_flag",  exp_r.flag,  o_offset_flag);
                if (!ok) begin
                    n_mismatch++;
                end
                if (exp_r.flag == FLAG_SAT) n_sat_seen++;
                if (exp_r.flag == FLAG_UNDEF) n_undef_seen++;
            end
            n_results++;
        end
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic write_frame_reg(logic [IDX_W-1:0] idx, longint val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= POS_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ROT_W || idx == REG_ROT_X || idx == REG_ROT_Y || idx == REG_ROT_Z) begin
            frame_reg[idx] = sext_to(val, ROT_W);
        end else if (idx != REG_UNUSED) begin
            frame_reg[idx] = sext_to(val, POS_W);
        end
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    // frame registers may only change with the pipe empty
    task automatic wait_idle();
        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic load_frame(longint qw, longint qx, longint qy, longint qz,
                              longint sx, longint sy, longint sz);
        wait_idle();
        write_frame_reg(REG_ROT_W, qw);
        write_frame_reg(REG_ROT_X, qx);
        write_frame_reg(REG_ROT_Y, qy);
        write_frame_reg(REG_ROT_Z, qz);
        write_frame_reg(REG_SHIFT_X, sx);
        write_frame_reg(REG_SHIFT_Y, sy);
        write_frame_reg(REG_SHIFT_Z, sz);
    endtask

    task automatic send_gaze(t_gaze_req rq, bit typed, t_gaze_res typed_res);
        int gap;
        int pick;
        i_valid    <= 1'b1;
        i_eye_x    <= POS_W'(rq.eye[0]);
        i_eye_y    <= POS_W'(rq.eye[1]);
        i_eye_z    <= POS_W'(rq.eye[2]);
        i_look_x   <= POS_W'(rq.look[0]);
        i_look_y   <= POS_W'(rq.look[1]);
        i_look_z   <= POS_W'(rq.look[2]);
        i_target_x <= POS_W'(rq.tgt[0]);
        i_target_y <= POS_W'(rq.tgt[1]);
        i_target_z <= POS_W'(rq.tgt[2]);
        do @(posedge i_clk); while (o_stall);
        pending_offsets.push_back(typed ? typed_res : predict_offset(rq));
        n_requests++;
        // mostly short gaps, a few long ones
        gap = 0;
        if ($urandom_range(0, 99) < sender_gap_pct) begin
            pick = $urandom_range(0, 99);
            gap  = (pick < 85) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int rand_pos24();
        return int'(sext_to(longint'($urandom()), POS_W));
    endfunction

    function automatic int edge_val();
        case ($urandom_range(0, 5))
            0: return -8388608;
            1: return 8388607;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return Q_ONE;
        endcase
    endfunction

    // Mostly plausible gaze samples: positions within a few metres, look
    // roughly unit length. The rest is raw noise and corner values.
    function automatic t_gaze_req rand_gaze();
        t_gaze_req rq;
        int kind;
        int ax;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            if (kind < 65) begin
                rq.eye[i]  = $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
                rq.tgt[i]  = $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
                rq.look[i] = $urandom_range(0, Q_ONE) - Q_ONE / 2;
            end else if (kind < 85) begin
                rq.eye[i]  = rand_pos24();
                rq.tgt[i]  = rand_pos24();
                rq.look[i] = rand_pos24();
            end else begin
                rq.eye[i]  = edge_val();
                rq.tgt[i]  = edge_val();
                rq.look[i] = edge_val();
            end
        end
        if (kind < 65) begin
            // push one axis to near unit so the look is close to normalized
            ax = $urandom_range(0, 2);
            rq.look[ax] = $urandom_range(0, 1) ? Q_ONE - $urandom_range(0, 4000)
                                               : -Q_ONE + $urandom_range(0, 4000);
            if ($urandom_range(0, 19) == 0) begin
                rq.tgt = rq.eye;    // target at the eye, identity-ish frames
            end
        end
        return rq;
    endfunction

    function automatic t_dir_row mk_row(int ex, int ey, int ez, int lx, int ly, int lz,
                                        int tx, int ty, int tz, bit typed,
                                        int tanv, t_flag fl);
        t_dir_row row;
        row.req.eye  = '{ex, ey, ez};
        row.req.look = '{lx, ly, lz};
        row.req.tgt  = '{tx, ty, tz};
        row.typed    = typed;
        // identity frame, zero shift: world values equal the inputs
        row.res.we   = '{ex, ey, ez};
        row.res.wl   = '{lx, ly, lz};
        row.res.tan  = tanv;
        row.res.flag = fl;
        return row;
    endfunction

    initial begin
        t_dir_row  dir_rows[$];
        t_gaze_res none;
        frame_reg = '{64'sd65536, 0, 0, 0, 0, 0, 0};

        // Directed requests, run with the reset frame (identity, no shift).
        // Typed rows are read straight off the math; the rest go through the predictor.
        dir_rows.push_back(mk_row(0, 0, 0, Q_ONE, 0, 0, 2 * Q_ONE, 0, 0,
                                  1, 0, FLAG_OK));                  // dead ahead
        dir_rows.push_back(mk_row(0, 0, 0, Q_ONE, 0, 0, Q_ONE, Q_ONE, 0,
                                  1, Q_ONE, FLAG_OK));              // 45 degrees
        dir_rows.push_back(mk_row(0, 0, 0, 2 * Q_ONE, 0, 0, Q_ONE, 0, 0,
                                  1, 0, FLAG_OK));                  // long look, radicand < 0
        dir_rows.push_back(mk_row(Q_ONE, Q_ONE, Q_ONE, 0, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE,
                                  1, 0, FLAG_UNDEF));               // target at eye
        dir_rows.push_back(mk_row(8388607, 8388607, 8388607, 0, 0, 0, 0, 0, 0,
                                  1, 0, FLAG_UNDEF));               // zero look, max eye
        dir_rows.push_back(mk_row(0, 0, 0, 1, 0, 0, 1, 8388607, 0,
                                  1, 32'h7FFF_FFFF, FLAG_SAT));     // huge tangent, ahead
        dir_rows.push_back(mk_row(0, 0, 0, 1, 0, 0, -1, 8388607, 0,
                                  1, 32'h8000_0000, FLAG_SAT));     // huge tangent, behind
        dir_rows.push_back(mk_row(0, 0, 0, Q_ONE, 0, 0, -2 * Q_ONE, Q_ONE, 0,
                                  0, 0, FLAG_OK));                  // target behind
        dir_rows.push_back(mk_row(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                                  8388607, 8388607, 8388607, 0, 0, FLAG_OK));
        dir_rows.push_back(mk_row(8388607, -8388608, 0, 8388607, 8388607, 8388607,
                                  -8388608, 8388607, -1, 0, 0, FLAG_OK));
        dir_rows.push_back(mk_row(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 0, FLAG_OK));
        dir_rows.push_back(mk_row(0, 0, 0, 0, 0, Q_ONE, 100, -300, 5 * Q_ONE,
                                  0, 0, FLAG_OK));
        dir_rows.push_back(mk_row(Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, Q_ONE, 3,
                                  0, 0, FLAG_OK));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_gaze(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
        end
        i_valid <= 1'b0;

        // Random phases, each with its own frame. The frame reload waits for the
        // pipe to drain, which also pauses the sender until all results are back.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: load_frame(65536, 0, 0, 0, 0, 0, 0);
                1: load_frame(46341, 0, 0, 46341, Q_ONE, -2 * Q_ONE, Q_ONE / 2);  // 90 deg on z
                2: load_frame(-131072, 131071, -131072, 131071,
                              8388607, -8388608, 8388607);                        // extremes
                3: load_frame(131071, -131072, 131071, -131072,
                              -8388608, 8388607, -8388608);
                4: load_frame($urandom_range(0, 65536), $urandom_range(0, 65536) - 32768,
                              $urandom_range(0, 65536) - 32768, $urandom_range(0, 65536) - 32768,
                              $urandom_range(0, 4 * Q_ONE), $urandom_range(0, 4 * Q_ONE),
                              $urandom_range(0, 4 * Q_ONE));
                default: load_frame($urandom(), $urandom(), $urandom(), $urandom(),
                                    $urandom(), $urandom(), $urandom());
            endcase
            if (ph == 1) begin
                write_frame_reg(REG_UNUSED, $urandom());   // must leave the frame alone
            end
            // vary pressure: one phase back to back, with only the occasional long receiver stall
            sender_gap_pct = (ph == 3) ? 0 : $urandom_range(5, 50);
            recv_stall_pct = (ph == 3) ? 0 : $urandom_range(5, 50);
            if (ph == 2) begin
                hold_req = 1'b1;      // output parked while requests keep coming
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_gaze(rand_gaze(), 1'b0, none);
            end
            i_valid <= 1'b0;
        end

        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);

        $display("%0d requests, %0d results (%0d saturated, %0d undefined), %0d frame writes",
                 n_requests, n_results, n_sat_seen, n_undef_seen, n_cfg_writes);
        $display("%0d mismatching results over %0d frame settings", n_mismatch, N_PHASES + 1);
        if (n_mismatch == 0 && pending_offsets.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gtao_pkg.sv
rtl/gtao_rot.sv
rtl/gtao_geom.sv
rtl/gtao_sqrt.sv
rtl/gtao_div.sv
rtl/gaze_target_angular_offset.sv
tb/tb_gaze_target_angular_offset.sv
